>>> design/assert_macros.svh
// Assertion macros shared by the dispense sequencer RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on each rising clock edge, off while reset is asserted.
`define DSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Plain condition checked on each rising clock edge, off while reset is asserted.
`define DSC_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

>>> design/dsc_pkg.sv
// Types and codes of the dispense sequencer. Used by dsc_core,
// dispense_sequence_controller and the sim benches; depends on nothing.
`default_nettype none

package dsc_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SOUND_ENABLED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_REQUIRED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WAIT_MS       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DISPENSE_MS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SLOT       = 3'd4;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_START  = 2'd1;
	localparam logic [1:0] ACT_MANUAL = 2'd2;
	localparam logic [1:0] ACT_CANCEL = 2'd3;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_ALERT    = 3'd1;
	localparam logic [2:0] PH_WAIT     = 3'd2;
	localparam logic [2:0] PH_MOVE     = 3'd3;
	localparam logic [2:0] PH_DISPENSE = 3'd4;
	localparam logic [2:0] PH_RETURN   = 3'd5;
	localparam logic [2:0] PH_COMPLETE = 3'd6;
	localparam logic [2:0] PH_ERROR    = 3'd7;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_TIMEOUT   = 2'd1;
	localparam logic [1:0] ERR_CANCELLED = 2'd2;

	typedef struct packed {
		logic        sound_enabled;
		logic        presence_required;
		logic [31:0] max_wait_ms;
		logic [31:0] dispense_ms;
		logic [2:0]  target_slot;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] now_ms;
		logic        presence;
		logic        motor_busy;
		logic [2:0]  current_slot;
	} item_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       start_accepted;
		logic       move_request;
		logic [2:0] move_target;
		logic       stop_motor;
		logic       play_alert;
		logic       finished_ok;
		logic       finished_error;
		logic [1:0] error_code;
		logic       busy_res;
	} result_t;

endpackage

`default_nettype wire

>>> design/dsc_core.sv
// Phase machine of the dispense sequencer: holds the phase, the phase entry
// time and the busy and skip-presence flags, and forms one result per request.
// Depends on dsc_pkg and assert_macros.svh.
`default_nettype none

module dsc_core #(
	parameter int unsigned NUM_SLOTS
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                commit,
	input  dsc_pkg::item_t     item,
	input  dsc_pkg::cfg_t      cfg,
	output dsc_pkg::result_t   res
);

	`include "assert_macros.svh"

	logic [2:0]  phase_q;
	logic [31:0] entry_q;
	logic        busy_q;
	logic        skip_q;

	logic [2:0]  phase_d;
	logic        busy_d;
	logic        skip_d;

	logic [7:0][2:0] next_tab;
	logic [2:0]      next_slot;

	for (genvar g = 0; g < 8; g++) begin : g_next
		localparam int unsigned NXT = ((g + 1) % NUM_SLOTS) & 7;
		assign next_tab[g] = NXT[2:0];
	end

	assign next_slot = next_tab[cfg.target_slot];

	always_comb begin
		logic [31:0] elapsed;
		logic        need_presence;
		logic        need_start;
		logic        manual;

		elapsed = item.now_ms - entry_q;
		need_presence = cfg.presence_required && !skip_q;
		manual = (item.action == dsc_pkg::ACT_MANUAL);
		need_start = cfg.presence_required && !manual;

		phase_d = phase_q;
		busy_d = busy_q;
		skip_d = skip_q;
		res = '0;

		case (item.action) inside
			dsc_pkg::ACT_START, dsc_pkg::ACT_MANUAL: begin
				if (!busy_q) begin
					res.start_accepted = 1'b1;
					busy_d = 1'b1;
					skip_d = manual;
					if (cfg.sound_enabled) begin
						phase_d = dsc_pkg::PH_ALERT;
					end else if (need_start) begin
						phase_d = dsc_pkg::PH_WAIT;
					end else begin
						phase_d = dsc_pkg::PH_MOVE;
					end
				end
			end
			dsc_pkg::ACT_CANCEL: begin
				res.stop_motor = 1'b1;
				busy_d = 1'b0;
				phase_d = dsc_pkg::PH_ERROR;
				res.finished_error = 1'b1;
				res.error_code = dsc_pkg::ERR_CANCELLED;
			end
			default: begin
				unique case (phase_q) inside
					dsc_pkg::PH_ALERT: begin
						res.play_alert = 1'b1;
						phase_d = need_presence ? dsc_pkg::PH_WAIT : dsc_pkg::PH_MOVE;
					end
					dsc_pkg::PH_WAIT: begin
						if (item.presence) begin
							phase_d = dsc_pkg::PH_MOVE;
						end else if (elapsed > cfg.max_wait_ms) begin
							busy_d = 1'b0;
							phase_d = dsc_pkg::PH_ERROR;
							res.finished_error = 1'b1;
							res.error_code = dsc_pkg::ERR_TIMEOUT;
						end
					end
					dsc_pkg::PH_MOVE: begin
						if (!item.motor_busy) begin
							if (item.current_slot == cfg.target_slot) begin
								phase_d = dsc_pkg::PH_DISPENSE;
							end else begin
								res.move_request = 1'b1;
								res.move_target = cfg.target_slot;
							end
						end
					end
					dsc_pkg::PH_DISPENSE: begin
						if (elapsed >= cfg.dispense_ms) begin
							phase_d = dsc_pkg::PH_RETURN;
						end
					end
					dsc_pkg::PH_RETURN: begin
						if (!item.motor_busy) begin
							if (item.current_slot == next_slot) begin
								busy_d = 1'b0;
								phase_d = dsc_pkg::PH_COMPLETE;
								res.finished_ok = 1'b1;
							end else begin
								res.move_request = 1'b1;
								res.move_target = next_slot;
							end
						end
					end
					dsc_pkg::PH_COMPLETE, dsc_pkg::PH_ERROR: begin
						phase_d = dsc_pkg::PH_IDLE;
					end
					default: begin
					end
				endcase
			end
		endcase

		res.phase = phase_d;
		res.busy_res = busy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dsc_pkg::PH_IDLE;
			entry_q <= '0;
			busy_q <= 1'b0;
			skip_q <= 1'b0;
		end else if (commit) begin
			phase_q <= phase_d;
			busy_q <= busy_d;
			skip_q <= skip_d;
			if (phase_d != phase_q) begin
				entry_q <= item.now_ms;
			end
		end
	end

	`DSC_ASSERT(a_cancel_to_error, commit && item.action == dsc_pkg::ACT_CANCEL |=> phase_q == dsc_pkg::PH_ERROR && !busy_q, "cancel did not end the sequence")
	`DSC_ASSERT(a_rest_not_busy, phase_q == dsc_pkg::PH_IDLE || phase_q == dsc_pkg::PH_COMPLETE || phase_q == dsc_pkg::PH_ERROR |-> !busy_q, "busy outside a running sequence")
	`DSC_ASSERT(a_entry_on_change, !$stable(entry_q) |-> !$stable(phase_q), "entry time moved without a phase change")

endmodule

`default_nettype wire

>>> design/dispense_sequence_controller.sv
// Top level of the dispense sequencer: configuration registers, request and
// result registers around the phase machine. Depends on dsc_pkg, dsc_core
// and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall  action now_ms presence motor_busy current_slot
//   result    out        out_valid/out_stall  phase start_accepted move_request move_target
//                                             stop_motor play_alert finished_ok
//                                             finished_error error_code busy_res
//   config    in         cfg_we               cfg_index cfg_wdata
//
// One request per cycle unless in_stall; each result is registered from the input register.
// The phase machine updates as a request leaves the input register, so requests chain
// cycle to cycle with no gap.
// arst_n clears the phase machine and loads the register defaults.
// out_stall holds the result register; in_stall rises only while both registers are full.
`default_nettype none

module dispense_sequence_controller #(
	parameter int unsigned NUM_SLOTS = 8
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [1:0]                     action,
	input  wire  [31:0]                    now_ms,
	input  wire                            presence,
	input  wire                            motor_busy,
	input  wire  [2:0]                     current_slot,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [2:0]                     phase,
	output logic                           start_accepted,
	output logic                           move_request,
	output logic [2:0]                     move_target,
	output logic                           stop_motor,
	output logic                           play_alert,
	output logic                           finished_ok,
	output logic                           finished_error,
	output logic [1:0]                     error_code,
	output logic                           busy_res,
	input  wire                            cfg_we,
	input  wire  [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [dsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	`include "assert_macros.svh"

	dsc_pkg::cfg_t    cfg_q;
	dsc_pkg::item_t   item_s1;
	logic             valid_s1;
	dsc_pkg::result_t res_s2;
	logic             valid_s2;
	dsc_pkg::result_t res;
	logic             adv;
	logic [3:0]       pulses_s2;

	assign adv = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sound_enabled <= 1'b1;
			cfg_q.presence_required <= 1'b1;
			cfg_q.max_wait_ms <= 32'd30000;
			cfg_q.dispense_ms <= 32'd5000;
			cfg_q.target_slot <= 3'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dsc_pkg::REG_SOUND_ENABLED:     cfg_q.sound_enabled <= cfg_wdata[0];
				dsc_pkg::REG_PRESENCE_REQUIRED: cfg_q.presence_required <= cfg_wdata[0];
				dsc_pkg::REG_MAX_WAIT_MS:       cfg_q.max_wait_ms <= cfg_wdata[31:0];
				dsc_pkg::REG_DISPENSE_MS:       cfg_q.dispense_ms <= cfg_wdata[31:0];
				dsc_pkg::REG_TARGET_SLOT:       cfg_q.target_slot <= cfg_wdata[2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action <= action;
			item_s1.now_ms <= now_ms;
			item_s1.presence <= presence;
			item_s1.motor_busy <= motor_busy;
			item_s1.current_slot <= current_slot;
		end
		if (valid_s1 && adv) begin
			res_s2 <= res;
		end
	end

	dsc_core #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.commit(valid_s1 && adv),
		.item  (item_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	assign out_valid = valid_s2;
	assign phase = res_s2.phase;
	assign start_accepted = res_s2.start_accepted;
	assign move_request = res_s2.move_request;
	assign move_target = res_s2.move_target;
	assign stop_motor = res_s2.stop_motor;
	assign play_alert = res_s2.play_alert;
	assign finished_ok = res_s2.finished_ok;
	assign finished_error = res_s2.finished_error;
	assign error_code = res_s2.error_code;
	assign busy_res = res_s2.busy_res;

	assign pulses_s2 = {res_s2.start_accepted, res_s2.move_request,
		res_s2.finished_ok, res_s2.finished_error};

	`DSC_ASSERT(a_pulses_exclusive, valid_s2 |-> $onehot0(pulses_s2), "conflicting result pulses")
	`DSC_ASSERT(a_error_code_pair, valid_s2 |-> res_s2.finished_error == (res_s2.error_code != dsc_pkg::ERR_NONE), "error code without error end")

endmodule

`default_nettype wire

>>> sim/dsc_sequence_checker.sv
`timescale 1ns / 1ps
// Checker for dispense_sequence_controller: mirrors register writes, predicts one result
// per accepted request and compares accepted results in order, field by field.
// Depends on dsc_pkg only.
module dsc_sequence_checker import dsc_pkg::*; #(
	parameter int unsigned NUM_SLOTS = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire                   in_stall,
	input  wire  [1:0]            action,
	input  wire  [31:0]           now_ms,
	input  wire                   presence,
	input  wire                   motor_busy,
	input  wire  [2:0]            current_slot,
	input  wire                   out_valid,
	input  wire                   out_stall,
	input  wire  [2:0]            phase,
	input  wire                   start_accepted,
	input  wire                   move_request,
	input  wire  [2:0]            move_target,
	input  wire                   stop_motor,
	input  wire                   play_alert,
	input  wire                   finished_ok,
	input  wire                   finished_error,
	input  wire  [1:0]            error_code,
	input  wire                   busy_res,
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_wdata,
	output logic [31:0]           pending,
	output logic [31:0]           fails
);

	cfg_t        cfg;
	logic [2:0]  cur_phase;
	logic [31:0] entry_ms;
	logic        busy;
	logic        skip_pres;
	result_t     expected_results[$];
	result_t     got;
	result_t     want;
	int unsigned checked = 0;
	int unsigned mismatch_count = 0;

	assign fails = mismatch_count;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at result %0d: %s", checked, msg);
	endtask

	function automatic void enter_phase(input logic [2:0] p, input logic [31:0] t);
		if (p != cur_phase) begin
			cur_phase = p;
			entry_ms = t;
		end
	endfunction

	function automatic result_t step_sequencer(input item_t it);
		result_t     r;
		logic [2:0]  tgt;
		logic [2:0]  nxt;
		logic [31:0] elapsed;
		logic        need_pres;
		r = '0;
		tgt = cfg.target_slot;
		nxt = 3'((int'(tgt) + 1) % NUM_SLOTS);
		elapsed = it.now_ms - entry_ms;
		need_pres = cfg.presence_required && !skip_pres;
		case (it.action)
			ACT_START, ACT_MANUAL: begin
				if (!busy) begin
					r.start_accepted = 1'b1;
					busy = 1'b1;
					skip_pres = (it.action == ACT_MANUAL);
					need_pres = cfg.presence_required && !skip_pres;
					if (cfg.sound_enabled) begin
						enter_phase(PH_ALERT, it.now_ms);
					end else if (need_pres) begin
						enter_phase(PH_WAIT, it.now_ms);
					end else begin
						enter_phase(PH_MOVE, it.now_ms);
					end
				end
			end
			ACT_CANCEL: begin
				r.stop_motor = 1'b1;
				busy = 1'b0;
				enter_phase(PH_ERROR, it.now_ms);
				r.finished_error = 1'b1;
				r.error_code = ERR_CANCELLED;
			end
			default: begin
				case (cur_phase)
					PH_ALERT: begin
						r.play_alert = 1'b1;
						enter_phase(need_pres ? PH_WAIT : PH_MOVE, it.now_ms);
					end
					PH_WAIT: begin
						if (it.presence) begin
							enter_phase(PH_MOVE, it.now_ms);
						end else if (elapsed > cfg.max_wait_ms) begin
							busy = 1'b0;
							enter_phase(PH_ERROR, it.now_ms);
							r.finished_error = 1'b1;
							r.error_code = ERR_TIMEOUT;
						end
					end
					PH_MOVE: begin
						if (!it.motor_busy) begin
							if (it.current_slot == tgt) begin
								enter_phase(PH_DISPENSE, it.now_ms);
							end else begin
								r.move_request = 1'b1;
								r.move_target = tgt;
							end
						end
					end
					PH_DISPENSE: begin
						if (elapsed >= cfg.dispense_ms) begin
							enter_phase(PH_RETURN, it.now_ms);
						end
					end
					PH_RETURN: begin
						if (!it.motor_busy) begin
							if (it.current_slot == nxt) begin
								busy = 1'b0;
								enter_phase(PH_COMPLETE, it.now_ms);
								r.finished_ok = 1'b1;
							end else begin
								r.move_request = 1'b1;
								r.move_target = nxt;
							end
						end
					end
					PH_COMPLETE, PH_ERROR: begin
						enter_phase(PH_IDLE, it.now_ms);
					end
					default: ;
				endcase
			end
		endcase
		r.phase = cur_phase;
		r.busy_res = busy;
		return r;
	endfunction

	task automatic compare_result(input result_t g, input result_t w);
		if (g.phase !== w.phase)
			report_mismatch($sformatf("phase %0d, want %0d", g.phase, w.phase));
		if (g.start_accepted !== w.start_accepted)
			report_mismatch($sformatf("start_accepted %b, want %b",
				g.start_accepted, w.start_accepted));
		if (g.move_request !== w.move_request)
			report_mismatch($sformatf("move_request %b, want %b",
				g.move_request, w.move_request));
		if (g.move_target !== w.move_target)
			report_mismatch($sformatf("move_target %0d, want %0d",
				g.move_target, w.move_target));
		if (g.stop_motor !== w.stop_motor)
			report_mismatch($sformatf("stop_motor %b, want %b", g.stop_motor, w.stop_motor));
		if (g.play_alert !== w.play_alert)
			report_mismatch($sformatf("play_alert %b, want %b", g.play_alert, w.play_alert));
		if (g.finished_ok !== w.finished_ok)
			report_mismatch($sformatf("finished_ok %b, want %b",
				g.finished_ok, w.finished_ok));
		if (g.finished_error !== w.finished_error)
			report_mismatch($sformatf("finished_error %b, want %b",
				g.finished_error, w.finished_error));
		if (g.error_code !== w.error_code)
			report_mismatch($sformatf("error_code %0d, want %0d", g.error_code, w.error_code));
		if (g.busy_res !== w.busy_res)
			report_mismatch($sformatf("busy_res %b, want %b", g.busy_res, w.busy_res));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg = '{1'b1, 1'b1, 32'd30000, 32'd5000, 3'd0};
			cur_phase = PH_IDLE;
			entry_ms = '0;
			busy = 1'b0;
			skip_pres = 1'b0;
			expected_results.delete();
			pending <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SOUND_ENABLED:     cfg.sound_enabled = cfg_wdata[0];
					REG_PRESENCE_REQUIRED: cfg.presence_required = cfg_wdata[0];
					REG_MAX_WAIT_MS:       cfg.max_wait_ms = cfg_wdata;
					REG_DISPENSE_MS:       cfg.dispense_ms = cfg_wdata;
					REG_TARGET_SLOT:       cfg.target_slot = cfg_wdata[2:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				expected_results.push_back(step_sequencer(item_t'({action, now_ms, presence,
					motor_busy, current_slot})));
			end
			if (out_valid && !out_stall) begin
				got = {phase, start_accepted, move_request, move_target, stop_motor,
					play_alert, finished_ok, finished_error, error_code, busy_res};
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result, phase %0d", got.phase));
				end else begin
					want = expected_results.pop_front();
					compare_result(got, want);
				end
				checked++;
			end
			pending <= expected_results.size();
		end
	end

endmodule

>>> sim/dispense_sequence_controller_tb.sv
`timescale 1ns / 1ps
// Testbench top for dispense_sequence_controller: clock, reset, register writes, request
// and result-stall stimulus, watchdog and verdict. Depends on dsc_pkg, the RTL top
// and dsc_sequence_checker, which does all prediction and comparison.
module dispense_sequence_controller_tb;
	import dsc_pkg::*;

	localparam int unsigned SLOTS = 8;
	localparam int unsigned IDLE_PCT = 27;
	localparam int unsigned PHASES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 200;
	localparam int unsigned QUIET_PHASE = 5;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            action = ACT_TICK;
	logic [31:0]           now_ms = '0;
	logic                  presence = 1'b0;
	logic                  motor_busy = 1'b0;
	logic [2:0]            current_slot = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            phase;
	logic                  start_accepted;
	logic                  move_request;
	logic [2:0]            move_target;
	logic                  stop_motor;
	logic                  play_alert;
	logic                  finished_ok;
	logic                  finished_error;
	logic [1:0]            error_code;
	logic                  busy_res;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SOUND_ENABLED;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic [31:0]           pending;
	logic [31:0]           fails;
	logic                  quiet = 1'b0;
	int unsigned           idle_cycles = 0;

	dispense_sequence_controller #(.NUM_SLOTS(SLOTS)) u_top (.*);

	dsc_sequence_checker #(.NUM_SLOTS(SLOTS)) u_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// hold the request until it is taken
	task automatic request(input logic [1:0] act, input logic [31:0] t, input logic pres,
		input logic mbusy, input logic [2:0] slot);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		now_ms <= t;
		presence <= pres;
		motor_busy <= mbusy;
		current_slot <= slot;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	initial begin
		cfg_t        c;
		logic [31:0] t;
		logic [31:0] t0;
		logic [1:0]  act;
		logic [2:0]  slot;
		int unsigned r;
		int unsigned presence_pct;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: sound on, presence required, target 0
		t0 = 32'hFFFF_FF00;
		request(ACT_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7);
		request(ACT_CANCEL, 32'h0, 1'b0, 1'b0, 3'd0);
		request(ACT_TICK, t0, 1'b0, 1'b0, 3'd0);
		request(ACT_START, t0, 1'b0, 1'b0, 3'd0);
		request(ACT_MANUAL, t0 + 1, 1'b0, 1'b0, 3'd0);
		request(ACT_TICK, t0 + 2, 1'b0, 1'b0, 3'd0);
		request(ACT_TICK, t0 + 30002, 1'b0, 1'b0, 3'd0);
		request(ACT_TICK, t0 + 30002, 1'b1, 1'b0, 3'd0);
		request(ACT_TICK, t0 + 30002, 1'b0, 1'b1, 3'd5);
		request(ACT_TICK, t0 + 30003, 1'b0, 1'b0, 3'd5);
		request(ACT_TICK, t0 + 30004, 1'b0, 1'b0, 3'd0);
		request(ACT_TICK, t0 + 35003, 1'b0, 1'b0, 3'd0);
		request(ACT_TICK, t0 + 35004, 1'b0, 1'b0, 3'd0);
		request(ACT_TICK, t0 + 35005, 1'b0, 1'b1, 3'd1);
		request(ACT_TICK, t0 + 35006, 1'b0, 1'b0, 3'd3);
		request(ACT_TICK, t0 + 35007, 1'b0, 1'b0, 3'd1);
		request(ACT_START, t0 + 35008, 1'b1, 1'b0, 3'd1);
		request(ACT_CANCEL, t0 + 35009, 1'b1, 1'b1, 3'd1);
		request(ACT_MANUAL, t0 + 35010, 1'b0, 1'b0, 3'd1);
		request(ACT_TICK, t0 + 35011, 1'b0, 1'b0, 3'd1);
		request(ACT_CANCEL, t0 + 35012, 1'b0, 1'b0, 3'd1);
		request(ACT_TICK, t0 + 35013, 1'b0, 1'b0, 3'd1);
		request(ACT_START, t0 + 35014, 1'b0, 1'b0, 3'd1);
		request(ACT_TICK, t0 + 35015, 1'b0, 1'b0, 3'd1);
		request(ACT_TICK, t0 + 65016, 1'b0, 1'b0, 3'd1);
		request(ACT_TICK, t0 + 65017, 1'b0, 1'b0, 3'd1);

		t = 32'hFFFF_FF80;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: c = '{1'b0, 1'b0, 32'd0, 32'd0, 3'd7};
				1: c = '{1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0};
				default: begin
					c.sound_enabled = 1'($urandom_range(1));
					c.presence_required = 1'($urandom_range(1));
					c.max_wait_ms = ($urandom_range(3) == 0) ? $urandom : $urandom_range(60);
					c.dispense_ms = ($urandom_range(7) == 0) ? $urandom : $urandom_range(60);
					c.target_slot = 3'($urandom_range(7));
				end
			endcase
			write_reg(REG_SOUND_ENABLED, 32'(c.sound_enabled));
			write_reg(REG_PRESENCE_REQUIRED, 32'(c.presence_required));
			write_reg(REG_MAX_WAIT_MS, c.max_wait_ms);
			write_reg(REG_DISPENSE_MS, c.dispense_ms);
			write_reg(REG_TARGET_SLOT, 32'(c.target_slot));
			cfg_we <= 1'b0;
			quiet <= (p == QUIET_PHASE);
			presence_pct = $urandom_range(20, 90);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = $urandom_range(99);
				if (r < 78) act = ACT_TICK;
				else if (r < 88) act = ACT_START;
				else if (r < 96) act = ACT_MANUAL;
				else act = ACT_CANCEL;
				case ($urandom_range(19))
					0: t = $urandom;
					1: t = t - $urandom_range(1, 40);
					default: t = t + $urandom_range(0, 12);
				endcase
				r = $urandom_range(99);
				if (r < 45) slot = c.target_slot;
				else if (r < 80) slot = 3'((int'(c.target_slot) + 1) % SLOTS);
				else slot = 3'($urandom_range(7));
				request(act, t, $urandom_range(99) < presence_pct,
					$urandom_range(99) < 25, slot);
			end
		end

		settle();
		@(negedge clk);
		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/dsc_pkg.sv
design/dsc_core.sv
design/dispense_sequence_controller.sv
sim/dsc_sequence_checker.sv
sim/dispense_sequence_controller_tb.sv
